### rtl/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the measurement frame smoother: item structs, state codes,
// tag, range and register index codes, and fixed arithmetic constants.
// No dependencies.
package mfs_pkg;

	// Fixed field widths
	localparam int TAG_W          = 4;
	localparam int COUNT_FIELD_W  = 32;
	localparam int FREQ_W         = 32;
	localparam int DUTY_W         = 15;
	localparam int INTERVAL_W     = 63;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 24;
	localparam int INT_THR_W      = 24;
	localparam int PERIOD_W       = 8;

	// Input item
	typedef struct packed {
		logic [TAG_W-1:0]         tag;
		logic [COUNT_FIELD_W-1:0] count_value;
	} mfs_in_t;

	// Result item
	typedef struct packed {
		logic [FREQ_W-1:0]     frequency_hz;
		logic [DUTY_W-1:0]     duty_percent_q8;
		logic [INTERVAL_W-1:0] interval_ns_q16;
		logic                  duty_valid;
	} mfs_out_t;

	// Divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mfs_div_stat_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DUTY_DIV,
		ST_DUTY_SMOOTH,
		ST_COUNT,
		ST_INT_SCALE,
		ST_INT_DIV,
		ST_INT_CHK,
		ST_INT_PREP,
		ST_INT_SMOOTH,
		ST_DONE
	} mfs_state_t;

	// Frame tags
	localparam logic [TAG_W-1:0] TAG_FREQ      = 4'd1;
	localparam logic [TAG_W-1:0] TAG_LOW       = 4'd3;
	localparam logic [TAG_W-1:0] TAG_HIGH      = 4'd4;
	localparam logic [TAG_W-1:0] TAG_INTERVAL  = 4'd5;
	localparam logic [TAG_W-1:0] TAG_RANGE     = 4'd6;

	// Interval range codes
	localparam int RANGE_X1    = 1;
	localparam int RANGE_X500  = 2;
	localparam int RANGE_X5000 = 3;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_THR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INT_THR    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLK_PERIOD = 2'd2;

	// Register reset values
	localparam logic [DUTY_W-1:0]    DUTY_THR_RST   = 15'd384;
	localparam logic [INT_THR_W-1:0] INT_THR_RST    = 24'd327680;
	localparam logic [PERIOD_W-1:0]  CLK_PERIOD_RST = 8'd20;

	// Count reset values
	localparam int FREQ_RST     = 1;
	localparam int LOW_RST      = 3;
	localparam int HIGH_RST     = 4;
	localparam int INTERVAL_RST = 5;

	// Arithmetic constants
	localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;
	localparam int SMOOTH_DIV    = 5;
	localparam int SMOOTH_ROUND  = 2;
	localparam int RANGE2_DIV    = 500;
	localparam int RANGE2_ROUND  = 250;
	localparam int RANGE3_DIV    = 5000;
	localparam int RANGE3_ROUND  = 2500;
	localparam int CONST_DEN_W   = $clog2(RANGE3_DIV + 1);
	localparam int Q16_SHIFT     = 16;
	localparam int DUTY_MUL_W    = 15;
	localparam int DUTY_SMOOTH_W = 17;

endpackage
`default_nettype wire

### rtl/measurement_frame_smoother_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Measurement frame smoother top level: count store, duty and interval
// sequencer, configuration registers and result register.
// Depends on mfs_pkg and mfs_sdiv.
//
//   Channel  Handshake           Payload
//   in       in_valid/in_stall   in_data   (mfs_in_t: tag, count_value)
//   out      out_valid/out_stall out_data  (mfs_out_t: four result fields)
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data (ready is always high)
//
// One item at a time. An ordinary frame runs the duty steps from accept to result;
// a tag 6 frame with a valid range adds the interval scaling and smoothing steps.
// All divisions share one divider, which yields one quotient bit per cycle.
// Zero duty sum skips the duty division. Reset returns counts to their reset values.
// A finished result waits in the output register while the next item is taken in.
module measurement_frame_smoother_core
	import mfs_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire mfs_in_t           in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output mfs_out_t               out_data,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW         = COUNT_WIDTH;
	localparam int SUM_W      = CW + 1;
	localparam int DUTY_NUM_W = CW + DUTY_MUL_W;
	localparam int PROD_W     = CW + PERIOD_W;
	localparam int X_W        = PROD_W + Q16_SHIFT;
	localparam int NUM_W      = X_W + 3;
	localparam int DEN_W      = (SUM_W > CONST_DEN_W) ? SUM_W : CONST_DEN_W;
	localparam int STEP_W     = $clog2(NUM_W + 1);
	localparam int DUTY_SHIFT = NUM_W - DUTY_NUM_W;
	localparam int DSM_SHIFT  = NUM_W - DUTY_SMOOTH_W;
	localparam int X_SHIFT    = NUM_W - X_W;

	mfs_state_t        state_q, state_d;
	mfs_div_stat_t     div_stat;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [STEP_W-1:0] div_steps;
	logic [NUM_W-1:0]  div_quo;
	logic              out_load;

	logic [TAG_W-1:0]    tag_q;
	logic [CW-1:0]       cnt_q;
	logic                duty_valid_q;
	logic [CW-1:0]       freq_count_q;
	logic [CW-1:0]       low_count_q;
	logic [CW-1:0]       high_count_q;
	logic [CW-1:0]       interval_count_q;
	logic [DUTY_W-1:0]   duty_last_q;
	logic [X_W-1:0]      interval_last_q;
	logic [PROD_W-1:0]   prod_q;
	logic [X_W-1:0]      xval_q;
	logic [DUTY_W-1:0]   duty_thr_q;
	logic [INT_THR_W-1:0] int_thr_q;
	logic [PERIOD_W-1:0] clk_period_q;
	logic                out_valid_q;
	mfs_out_t            out_data_q;

	logic [SUM_W-1:0]         duty_sum;
	logic                     sum_nz;
	logic [DUTY_NUM_W-1:0]    duty_num;
	logic [DUTY_W-1:0]        raw_duty;
	logic [DUTY_W-1:0]        duty_diff;
	logic                     duty_jump;
	logic [DUTY_SMOOTH_W-1:0] duty_smooth_num;
	logic [X_W-1:0]           x_full;
	logic [X_W-1:0]           x_round;
	logic [X_W-1:0]           int_diff;
	logic                     int_jump;
	logic [NUM_W-1:0]         int_smooth_num;
	logic                     range_one;
	logic                     range_two;
	logic                     range_three;

	// Duty ratio operands from the counts held before this frame
	assign duty_sum = SUM_W'(low_count_q) + SUM_W'(high_count_q);
	assign sum_nz   = (duty_sum != '0);
	assign duty_num = DUTY_NUM_W'(high_count_q) * DUTY_NUM_W'(DUTY_FULL);
	assign raw_duty = div_quo[DUTY_W-1:0];

	// Duty jump test and smoothing numerator
	always_comb begin
		if (raw_duty > duty_last_q) begin
			duty_diff = raw_duty - duty_last_q;
		end else begin
			duty_diff = duty_last_q - raw_duty;
		end
	end
	assign duty_jump       = (duty_diff > duty_thr_q);
	assign duty_smooth_num = DUTY_SMOOTH_W'({duty_last_q, 2'b00})
		+ DUTY_SMOOTH_W'(raw_duty) + DUTY_SMOOTH_W'(SMOOTH_ROUND);

	// Interval scaling operands
	assign range_one   = (cnt_q == CW'(RANGE_X1));
	assign range_two   = (cnt_q == CW'(RANGE_X500));
	assign range_three = (cnt_q == CW'(RANGE_X5000));
	assign x_full      = {prod_q, {Q16_SHIFT{1'b0}}};
	assign x_round     = x_full + (range_two ? X_W'(RANGE2_ROUND) : X_W'(RANGE3_ROUND));

	// Interval jump test and smoothing numerator
	always_comb begin
		if (xval_q > interval_last_q) begin
			int_diff = xval_q - interval_last_q;
		end else begin
			int_diff = interval_last_q - xval_q;
		end
	end
	assign int_jump       = (int_diff > X_W'(int_thr_q));
	assign int_smooth_num = NUM_W'({interval_last_q, 2'b00}) + NUM_W'(xval_q)
		+ NUM_W'(SMOOTH_ROUND);

	// Shared serial divider
	mfs_sdiv #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, divider requests and handshake
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (sum_nz) begin
						div_start = 1'b1;
						div_num   = NUM_W'(duty_num) << DUTY_SHIFT;
						div_den   = DEN_W'(duty_sum);
						div_steps = STEP_W'(DUTY_NUM_W);
						state_d   = ST_DUTY_DIV;
					end else begin
						state_d = ST_COUNT;
					end
				end
			end
			ST_DUTY_DIV: begin
				if (div_stat.done) begin
					if (duty_jump) begin
						state_d = ST_COUNT;
					end else begin
						div_start = 1'b1;
						div_num   = NUM_W'(duty_smooth_num) << DSM_SHIFT;
						div_den   = DEN_W'(SMOOTH_DIV);
						div_steps = STEP_W'(DUTY_SMOOTH_W);
						state_d   = ST_DUTY_SMOOTH;
					end
				end
			end
			ST_DUTY_SMOOTH: begin
				if (div_stat.done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (tag_q == TAG_RANGE && (range_one || range_two || range_three)) begin
					state_d = ST_INT_SCALE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_INT_SCALE: begin
				if (range_one) begin
					state_d = ST_INT_CHK;
				end else begin
					div_start = 1'b1;
					div_num   = NUM_W'(x_round) << X_SHIFT;
					div_den   = range_two ? DEN_W'(RANGE2_DIV) : DEN_W'(RANGE3_DIV);
					div_steps = STEP_W'(X_W);
					state_d   = ST_INT_DIV;
				end
			end
			ST_INT_DIV: begin
				if (div_stat.done) begin
					state_d = ST_INT_CHK;
				end
			end
			ST_INT_CHK: begin
				state_d = int_jump ? ST_DONE : ST_INT_PREP;
			end
			ST_INT_PREP: begin
				div_start = 1'b1;
				div_num   = int_smooth_num;
				div_den   = DEN_W'(SMOOTH_DIV);
				div_steps = STEP_W'(NUM_W);
				state_d   = ST_INT_SMOOTH;
			end
			ST_INT_SMOOTH: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Stored counts and smoothed values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_count_q     <= CW'(FREQ_RST);
			low_count_q      <= CW'(LOW_RST);
			high_count_q     <= CW'(HIGH_RST);
			interval_count_q <= CW'(INTERVAL_RST);
			duty_last_q      <= '0;
			interval_last_q  <= '0;
		end else begin
			unique case (state_q)
				ST_DUTY_DIV: begin
					if (div_stat.done && duty_jump) begin
						duty_last_q <= raw_duty;
					end
				end
				ST_DUTY_SMOOTH: begin
					if (div_stat.done) begin
						duty_last_q <= div_quo[DUTY_W-1:0];
					end
				end
				ST_COUNT: begin
					unique case (tag_q)
						TAG_FREQ:     freq_count_q     <= cnt_q;
						TAG_LOW:      low_count_q      <= cnt_q;
						TAG_HIGH:     high_count_q     <= cnt_q;
						TAG_INTERVAL: interval_count_q <= cnt_q;
						default: begin
						end
					endcase
				end
				ST_INT_CHK: begin
					if (int_jump) begin
						interval_last_q <= xval_q;
					end
				end
				ST_INT_SMOOTH: begin
					if (div_stat.done) begin
						interval_last_q <= div_quo[X_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Frame capture, interval product and candidate value
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			tag_q        <= in_data.tag;
			cnt_q        <= in_data.count_value[CW-1:0];
			duty_valid_q <= sum_nz;
		end
		if (state_q == ST_COUNT) begin
			prod_q <= PROD_W'(interval_count_q) * PROD_W'(clk_period_q);
		end
		if (state_q == ST_INT_SCALE && range_one) begin
			xval_q <= x_full;
		end else if (state_q == ST_INT_DIV && div_stat.done) begin
			xval_q <= div_quo[X_W-1:0];
		end
		if (out_load) begin
			out_data_q.frequency_hz    <= FREQ_W'(freq_count_q);
			out_data_q.duty_percent_q8 <= DUTY_FULL - duty_last_q;
			out_data_q.interval_ns_q16 <= INTERVAL_W'(interval_last_q);
			out_data_q.duty_valid      <= duty_valid_q;
		end
	end

	// Output register valid flag: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers: drop writes beyond the list
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_thr_q   <= DUTY_THR_RST;
			int_thr_q    <= INT_THR_RST;
			clk_period_q <= CLK_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DUTY_THR:   duty_thr_q   <= cfg_data[DUTY_W-1:0];
				CFG_INT_THR:    int_thr_q    <= cfg_data[INT_THR_W-1:0];
				CFG_CLK_PERIOD: clk_period_q <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_duty_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUTY_DIV && div_stat.done) |-> (div_quo <= NUM_W'(DUTY_FULL)))
		else $error("raw duty above full scale");

	a_duty_last: assert property (@(posedge clk) disable iff (!arst_n)
		duty_last_q <= DUTY_FULL)
		else $error("smoothed duty above full scale");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && state_d == ST_IDLE) |=> out_valid)
		else $error("finished item not presented");

endmodule
`default_nettype wire

### rtl/mfs_sdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on mfs_pkg for the status struct.
module mfs_sdiv
	import mfs_pkg::*;
#(
	parameter int NUM_W = 59,
	parameter int DEN_W = 33
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [NUM_W-1:0]               num,
	input  wire [DEN_W-1:0]               den,
	input  wire [$clog2(NUM_W + 1)-1:0]   steps,
	output mfs_div_stat_t                 stat,
	output logic [NUM_W-1:0]              quo
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic              busy;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    trial;
	logic              fits;

	// Bring down the next dividend bit and try the subtraction
	assign busy    = (cnt_q != '0);
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1));
			if (start) begin
				cnt_q <= steps;
			end else if (busy) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	// Remainder and dividend shift register; quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= num;
		end else if (busy) begin
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy;
	assign stat.done = done_q;
	assign quo       = num_q;

	a_start_steps: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (steps != '0))
		else $error("divider started with no steps");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0))
		else $error("divider flagged done while still stepping");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

### dv/tb_measurement_frame_smoother_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for measurement_frame_smoother_core: frames in, one
// result per frame out, checked field by field against a behavioural model of
// the duty and interval smoothing. Depends on mfs_pkg and the core RTL.
module tb_measurement_frame_smoother_core;
	import mfs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int END_SETTLE  = 400;
	localparam int HOLD_CYCLES = 1500;

	// Codes that the package leaves unnamed
	localparam logic [TAG_W-1:0]       TAG_NONE     = 4'd0;
	localparam logic [TAG_W-1:0]       TAG_AUX      = 4'd2;
	localparam logic [TAG_W-1:0]       TAG_SPARE_LO = 4'd7;
	localparam logic [TAG_W-1:0]       TAG_SPARE_HI = 4'd15;
	localparam logic [31:0]            RANGE_NONE   = 32'd0;
	localparam logic [31:0]            RANGE_SPARE  = 32'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED   = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	mfs_in_t                in_data;
	logic                   out_valid;
	logic                   out_stall;
	mfs_out_t               out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	measurement_frame_smoother_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model state and register copies
	logic [31:0]           freq_cnt;
	logic [31:0]           low_cnt;
	logic [31:0]           high_cnt;
	logic [31:0]           interval_cnt;
	logic [DUTY_W-1:0]     duty_hist;
	logic [INTERVAL_W-1:0] interval_hist;
	logic [DUTY_W-1:0]     duty_thr;
	logic [INT_THR_W-1:0]  int_thr;
	logic [PERIOD_W-1:0]   clk_period;

	mfs_out_t pending_results[$];

	// Stimulus bases for well-formed sequences
	logic [31:0] low_base;
	logic [31:0] high_base;
	logic [31:0] interval_base;

	bit send_gaps;
	bit recv_gaps;
	int hold_len;
	int errors;
	int frames_sent;
	int results_checked;
	int cfg_writes;
	int cycle_count;

	// Free-running clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Blend a fresh value into the last one unless it jumps past the threshold
	function automatic logic [63:0] blend(input logic [63:0] last, input logic [63:0] fresh,
		input logic [63:0] thr);
		logic [63:0] diff;
		diff = (last > fresh) ? last - fresh : fresh - last;
		if (diff > thr)
			return fresh;
		return (64'(4) * last + fresh + 64'(SMOOTH_ROUND)) / 64'(SMOOTH_DIV);
	endfunction

	// Advance the model by one frame and return the result it produces
	function automatic mfs_out_t predict_frame(input mfs_in_t frame);
		logic [63:0] span;
		logic [63:0] ratio;
		logic [63:0] scaled;
		logic        valid;
		logic        have;
		mfs_out_t    r;
		span  = 64'(low_cnt) + 64'(high_cnt);
		valid = 1'b0;
		// duty uses the counts held before this frame
		if (span != 0) begin
			ratio = (64'(high_cnt) * 64'(DUTY_FULL)) / span;
			if (ratio > 64'(DUTY_FULL))
				ratio = 64'(DUTY_FULL);
			ratio = blend(64'(duty_hist), ratio, 64'(duty_thr));
			if (ratio > 64'(DUTY_FULL))
				ratio = 64'(DUTY_FULL);
			duty_hist = ratio[DUTY_W-1:0];
			valid = 1'b1;
		end
		case (frame.tag)
			TAG_FREQ:     freq_cnt = frame.count_value;
			TAG_LOW:      low_cnt = frame.count_value;
			TAG_HIGH:     high_cnt = frame.count_value;
			TAG_INTERVAL: interval_cnt = frame.count_value;
			TAG_RANGE: begin
				scaled = (64'(interval_cnt) * 64'(clk_period)) << Q16_SHIFT;
				have = 1'b1;
				if (frame.count_value == RANGE_X500)
					scaled = (scaled + 64'(RANGE2_ROUND)) / 64'(RANGE2_DIV);
				else if (frame.count_value == RANGE_X5000)
					scaled = (scaled + 64'(RANGE3_ROUND)) / 64'(RANGE3_DIV);
				else if (frame.count_value != RANGE_X1)
					have = 1'b0;
				if (have) begin
					scaled = blend(64'(interval_hist), scaled, 64'(int_thr));
					interval_hist = scaled[INTERVAL_W-1:0];
				end
			end
			default: ;
		endcase
		r.frequency_hz    = freq_cnt;
		r.duty_percent_q8 = DUTY_FULL - duty_hist;
		r.interval_ns_q16 = interval_hist;
		r.duty_valid      = valid;
		return r;
	endfunction

	// Offer one frame, hold it until taken, then record its expected result
	task automatic send_frame(input logic [TAG_W-1:0] tag, input logic [31:0] value);
		mfs_in_t frame;
		frame.tag         = tag;
		frame.count_value = value;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= frame;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_results.push_back(predict_frame(frame));
		frames_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_DUTY_THR:   duty_thr = value[DUTY_W-1:0];
			CFG_INT_THR:    int_thr = value[INT_THR_W-1:0];
			CFG_CLK_PERIOD: clk_period = value[PERIOD_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly well-formed count updates with small drift, plus random noise frames
	task automatic drive_measurement_mix(input int n);
		int          sent;
		int          pick;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] cnt;
		logic [31:0] rng;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 9);
			if (pick <= 2) begin
				if ($urandom_range(0, 7) == 0) begin
					low_base  = $urandom() >> $urandom_range(0, 31);
					high_base = $urandom() >> $urandom_range(0, 31);
				end
				lo = low_base + $urandom_range(0, low_base >> 6);
				hi = high_base + $urandom_range(0, high_base >> 6);
				send_frame(TAG_LOW, lo);
				send_frame(TAG_HIGH, hi);
				sent += 2;
			end else if (pick <= 5) begin
				if ($urandom_range(0, 7) == 0)
					interval_base = $urandom() >> $urandom_range(0, 31);
				cnt = interval_base + $urandom_range(0, 200);
				case ($urandom_range(0, 9))
					0:       rng = RANGE_X1;
					1:       rng = $urandom();
					2, 3, 4: rng = RANGE_X500;
					default: rng = RANGE_X5000;
				endcase
				send_frame(TAG_INTERVAL, cnt);
				send_frame(TAG_RANGE, rng);
				sent += 2;
			end else if (pick == 6) begin
				send_frame(TAG_FREQ, $urandom());
				sent++;
			end else begin
				cnt = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 7);
				send_frame(4'($urandom_range(0, 15)), cnt);
				sent++;
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want_v,
		input logic [63:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
	endtask

	// Check each result taken against the oldest expectation
	always @(posedge clk) begin : result_check
		mfs_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (out_data.frequency_hz !== want.frequency_hz)
					report_mismatch("frequency_hz", 64'(want.frequency_hz),
						64'(out_data.frequency_hz));
				if (out_data.duty_percent_q8 !== want.duty_percent_q8)
					report_mismatch("duty_percent_q8", 64'(want.duty_percent_q8),
						64'(out_data.duty_percent_q8));
				if (out_data.interval_ns_q16 !== want.interval_ns_q16)
					report_mismatch("interval_ns_q16", 64'(want.interval_ns_q16),
						64'(out_data.interval_ns_q16));
				if (out_data.duty_valid !== want.duty_valid)
					report_mismatch("duty_valid", 64'(want.duty_valid),
						64'(out_data.duty_valid));
			end
		end
	end

	// Receiver: a long hold on request, otherwise random stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_reset_state();
		send_frame(TAG_NONE, 32'd0);
		wait_drained();
	endtask

	// Count extremes, zero duty sum, duty with a zero low count, ignored tags
	task automatic test_count_extremes();
		send_frame(TAG_FREQ, 32'd0);
		send_frame(TAG_FREQ, 32'hFFFF_FFFF);
		send_frame(TAG_AUX, 32'hFFFF_FFFF);
		send_frame(TAG_LOW, 32'd0);
		send_frame(TAG_HIGH, 32'd0);
		send_frame(TAG_NONE, 32'd0);
		send_frame(TAG_HIGH, 32'hFFFF_FFFF);
		send_frame(TAG_LOW, 32'hFFFF_FFFF);
		send_frame(TAG_LOW, 32'd0);
		send_frame(TAG_SPARE_LO, 32'd5);
		send_frame(TAG_SPARE_HI, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// Every range code, unknown codes and the widest interval count
	task automatic test_interval_ranges();
		send_frame(TAG_INTERVAL, 32'hFFFF_FFFF);
		send_frame(TAG_RANGE, RANGE_X1);
		send_frame(TAG_RANGE, RANGE_X500);
		send_frame(TAG_RANGE, RANGE_X5000);
		send_frame(TAG_RANGE, RANGE_NONE);
		send_frame(TAG_RANGE, RANGE_SPARE);
		send_frame(TAG_RANGE, 32'hFFFF_FFFF);
		send_frame(TAG_INTERVAL, 32'd0);
		send_frame(TAG_RANGE, RANGE_X5000);
		wait_drained();
	endtask

	// Register extremes, masking, zero period and an unused index
	task automatic test_config_extremes();
		write_register(CFG_DUTY_THR, 24'd0);
		write_register(CFG_INT_THR, 24'd0);
		write_register(CFG_CLK_PERIOD, 24'd255);
		drive_measurement_mix(40);
		wait_drained();
		write_register(CFG_DUTY_THR, 24'hFF_FFFF);
		write_register(CFG_INT_THR, 24'hFF_FFFF);
		write_register(CFG_CLK_PERIOD, 24'd1);
		drive_measurement_mix(40);
		wait_drained();
		// period masks to zero, so every new interval is zero
		write_register(CFG_CLK_PERIOD, 24'h00_0100);
		send_frame(TAG_INTERVAL, 32'd1000);
		send_frame(TAG_RANGE, RANGE_X1);
		drive_measurement_mix(30);
		wait_drained();
		write_register(CFG_UNUSED, 24'hFF_FFFF);
		write_register(CFG_DUTY_THR, 24'd25600);
		write_register(CFG_INT_THR, 24'd16777215);
		write_register(CFG_CLK_PERIOD, 24'd20);
		drive_measurement_mix(40);
		wait_drained();
		write_register(CFG_DUTY_THR, 24'($urandom_range(0, 1000)));
		write_register(CFG_INT_THR, 24'($urandom_range(0, 2000000)));
		write_register(CFG_CLK_PERIOD, 24'($urandom_range(1, 255)));
		drive_measurement_mix(40);
		wait_drained();
	endtask

	// Hold the output long enough that the core fills and stalls its input
	task automatic test_output_backpressure();
		hold_len = HOLD_CYCLES;
		drive_measurement_mix(10);
		wait_drained();
	endtask

	task automatic test_sender_pause();
		drive_measurement_mix(20);
		wait_drained();
		drive_measurement_mix(20);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		write_register(CFG_DUTY_THR, 24'(DUTY_THR_RST));
		write_register(CFG_INT_THR, 24'(INT_THR_RST));
		write_register(CFG_CLK_PERIOD, 24'(CLK_PERIOD_RST));
		repeat (8) begin
			send_gaps = $urandom_range(0, 3) != 0;
			recv_gaps = $urandom_range(0, 3) != 0;
			drive_measurement_mix(25);
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		wait_drained();
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_steady_stream();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		drive_measurement_mix(100);
		wait_drained();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_gaps     = 1'b1;
		recv_gaps     = 1'b1;
		hold_len      = 0;
		errors        = 0;
		frames_sent   = 0;
		results_checked = 0;
		cfg_writes    = 0;
		cycle_count   = 0;
		low_base      = 32'd1000;
		high_base     = 32'd3000;
		interval_base = 32'd500;
		// model reset state
		freq_cnt      = FREQ_RST;
		low_cnt       = LOW_RST;
		high_cnt      = HIGH_RST;
		interval_cnt  = INTERVAL_RST;
		duty_hist     = '0;
		interval_hist = '0;
		duty_thr      = DUTY_THR_RST;
		int_thr       = INT_THR_RST;
		clk_period    = CLK_PERIOD_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_count_extremes();
		test_interval_ranges();
		test_config_extremes();
		test_output_backpressure();
		test_sender_pause();
		test_random_traffic();
		test_steady_stream();

		// Let any stray result show up before the verdict
		repeat (END_SETTLE) @(posedge clk);
		$display("Run covered %0d frames, %0d results checked, %0d register writes,",
			frames_sent, results_checked, cfg_writes);
		$display("through reset state, count extremes, all range codes and back-pressure.");
		if (errors == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
